### hw/rtl/aglp_pkg.sv
// Shared types and constants for the adaptive-gain low-pass filter.
// Holds the configuration register map, reset values and Q-format widths.
// No dependencies.
`default_nettype none

package aglp_pkg;

    // Q1.16 gain, one is 2**16.
    localparam int GAIN_BITS  = 17;
    localparam int FRAC_BITS  = 16;
    localparam int LEVEL_BITS = 32;
    localparam int COUNT_BITS = 9;
    localparam int THR_BITS   = 16;
    localparam int CTHR_BITS  = 8;
    localparam int BONUS_BITS = 4;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = 17'h10000;

    // Configuration write channel.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = GAIN_BITS;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;
    typedef logic [GAIN_BITS-1:0]      gain_t;

    // Register map.
    localparam cfg_index_t REG_SLOW_GAIN       = 3'd0;
    localparam cfg_index_t REG_FAST_GAIN       = 3'd1;
    localparam cfg_index_t REG_STEP_THRESHOLD  = 3'd2;
    localparam cfg_index_t REG_COUNT_THRESHOLD = 3'd3;
    localparam cfg_index_t REG_BIG_STEP_BONUS  = 3'd4;

    // Reset values.
    localparam gain_t                 RST_SLOW_GAIN       = 17'd655;
    localparam gain_t                 RST_FAST_GAIN       = 17'd32768;
    localparam logic [THR_BITS-1:0]   RST_STEP_THRESHOLD  = 16'd10;
    localparam logic [CTHR_BITS-1:0]  RST_COUNT_THRESHOLD = 8'd50;
    localparam logic [BONUS_BITS-1:0] RST_BIG_STEP_BONUS  = 4'd5;

    // Gains above one are held at one.
    function automatic gain_t cap_gain(input gain_t g);
        cap_gain = (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/adaptive_gain_lowpass_top.sv
// Adaptive-gain first-order low-pass filter, top level.
// Uses aglp_pkg for the register map, reset values and gain capping.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid / s_tready  s_tdata: sample
//   m_        out        m_tvalid / m_tready  m_tdata: filtered_value (Q16.16)
//   cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle is sustained while m_ is not stalled; each item passes
// through the input register and then the result register before it shows on
// m_. The filter recurrence (subtract, gain select, one multiply, round, add,
// saturate) is combinational and closes around the level register. Reset is
// synchronous on aresetn and restores the register defaults and a zero filter
// state. A stall on m_ holds the result register; one more item is still
// taken into the input register.
`default_nettype none

module adaptive_gain_lowpass_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    // Input stream.
    input  wire                                       s_tvalid,
    output logic                                      s_tready,
    input  wire  [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample
    // Result stream.
    output logic                                      m_tvalid,
    input  wire                                       m_tready,
    output logic [31:0]                               m_tdata,   // [31:0] filtered_value
    // Configuration writes.
    input  wire                                       cfg_valid,
    output logic                                      cfg_ready,
    input  wire  aglp_pkg::cfg_index_t                cfg_index,
    input  wire  aglp_pkg::cfg_data_t                 cfg_data
);
    import aglp_pkg::*;

    // Widths of the datapath.
    localparam int SHIFTED_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int DIFF_BITS    = ((SHIFTED_BITS > LEVEL_BITS) ? SHIFTED_BITS : LEVEL_BITS) + 1;
    localparam int PROD_BITS    = DIFF_BITS + GAIN_BITS + 1;
    localparam int SCALED_BITS  = PROD_BITS - FRAC_BITS;
    localparam int SUM_BITS     = SCALED_BITS + 1;

    // Configuration registers.
    gain_t                 slow_gain_reg;
    gain_t                 fast_gain_reg;
    logic [THR_BITS-1:0]   step_threshold_reg;
    logic [CTHR_BITS-1:0]  count_threshold_reg;
    logic [BONUS_BITS-1:0] big_step_bonus_reg;

    // Filter state.
    logic signed [LEVEL_BITS-1:0] filter_level_reg;
    gain_t                        active_gain_reg;
    logic [COUNT_BITS-1:0]        run_count_reg;
    logic                         rising_reg;

    // Pipeline registers.
    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          out_valid_reg;
    logic [LEVEL_BITS-1:0]         out_data_reg;

    // Datapath signals.
    logic                          advance;
    logic signed [DIFF_BITS-1:0]   diff;
    logic [DIFF_BITS-1:0]          diff_mag;
    logic [DIFF_BITS-1:0]          step_limit;
    logic                          rising_next;
    logic                          big_step;
    logic [COUNT_BITS-1:0]         run_count_bumped;
    logic [COUNT_BITS-1:0]         run_count_next;
    gain_t                         active_gain_next;
    logic signed [PROD_BITS-1:0]   product;
    logic signed [PROD_BITS-1:0]   product_rounded;
    logic signed [SCALED_BITS-1:0] scaled;
    logic signed [SUM_BITS-1:0]    level_sum;
    logic                          level_ovf;
    logic signed [LEVEL_BITS-1:0]  filter_level_next;

    // The input register moves forward when the result register is free or drains.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    // Difference between the new sample in Q16.16 and the current level.
    assign diff = $signed({{(DIFF_BITS - SHIFTED_BITS){sample_reg[SAMPLE_BITS-1]}},
                           sample_reg, {FRAC_BITS{1'b0}}})
                - $signed({{(DIFF_BITS - LEVEL_BITS){filter_level_reg[LEVEL_BITS-1]}},
                           filter_level_reg});

    assign diff_mag   = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
    assign step_limit = {{(DIFF_BITS - THR_BITS - FRAC_BITS){1'b0}},
                         step_threshold_reg, {FRAC_BITS{1'b0}}};
    assign big_step   = diff_mag > step_limit;

    // Direction tracking; an unchanged value keeps the last direction.
    always_comb begin
        rising_next = rising_reg;
        if (diff[DIFF_BITS-1]) begin
            rising_next = 1'b0;
        end else if (diff != '0) begin
            rising_next = 1'b1;
        end
    end

    // Run counter and gain selection.
    assign run_count_bumped = run_count_reg + COUNT_BITS'(1)
                            + (big_step ? COUNT_BITS'(big_step_bonus_reg) : '0);

    always_comb begin
        run_count_next   = run_count_bumped;
        active_gain_next = active_gain_reg;
        if (rising_next != rising_reg) begin
            run_count_next   = '0;
            active_gain_next = cap_gain(slow_gain_reg);
        end else if (run_count_bumped > COUNT_BITS'(count_threshold_reg)) begin
            run_count_next   = '0;
            active_gain_next = cap_gain(fast_gain_reg);
        end
    end

    // Level update: round half up, then saturate to 32 bits.
    assign product         = $signed({1'b0, active_gain_next}) * diff;
    assign product_rounded = product + PROD_BITS'(32'sd32768);
    assign scaled          = SCALED_BITS'(product_rounded >>> FRAC_BITS);
    assign level_sum       = $signed({scaled[SCALED_BITS-1], scaled})
                           + $signed({{(SUM_BITS - LEVEL_BITS){filter_level_reg[LEVEL_BITS-1]}},
                                      filter_level_reg});
    assign level_ovf       = !((&level_sum[SUM_BITS-1:LEVEL_BITS-1])
                            || !(|level_sum[SUM_BITS-1:LEVEL_BITS-1]));

    always_comb begin
        filter_level_next = level_sum[LEVEL_BITS-1:0];
        if (level_ovf) begin
            filter_level_next = level_sum[SUM_BITS-1] ? {1'b1, {(LEVEL_BITS-1){1'b0}}}
                                                      : {1'b0, {(LEVEL_BITS-1){1'b1}}};
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_gain_reg       <= RST_SLOW_GAIN;
            fast_gain_reg       <= RST_FAST_GAIN;
            step_threshold_reg  <= RST_STEP_THRESHOLD;
            count_threshold_reg <= RST_COUNT_THRESHOLD;
            big_step_bonus_reg  <= RST_BIG_STEP_BONUS;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SLOW_GAIN:       slow_gain_reg       <= cfg_data[GAIN_BITS-1:0];
                REG_FAST_GAIN:       fast_gain_reg       <= cfg_data[GAIN_BITS-1:0];
                REG_STEP_THRESHOLD:  step_threshold_reg  <= cfg_data[THR_BITS-1:0];
                REG_COUNT_THRESHOLD: count_threshold_reg <= cfg_data[CTHR_BITS-1:0];
                REG_BIG_STEP_BONUS:  big_step_bonus_reg  <= cfg_data[BONUS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Filter state and valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_level_reg <= '0;
            active_gain_reg  <= '0;
            run_count_reg    <= '0;
            rising_reg       <= 1'b0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg    <= 1'b1;
                filter_level_reg <= filter_level_next;
                active_gain_reg  <= active_gain_next;
                run_count_reg    <= run_count_next;
                rising_reg       <= rising_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (advance) begin
            out_data_reg <= filter_level_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The loaded gain never exceeds one.
    assert property (@(posedge aclk) disable iff (!aresetn) active_gain_reg <= GAIN_ONE)
        else $error("active gain above one");

    // The run counter is cleared before it can pass the largest threshold.
    assert property (@(posedge aclk) disable iff (!aresetn) !run_count_reg[COUNT_BITS-1])
        else $error("run counter out of range");

    // Input is refused only while an item sits in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn) !s_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // An item that moves forward shows up as a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) advance |=> m_tvalid)
        else $error("advanced item lost");
`endif

endmodule

`default_nettype wire

### test/adaptive_gain_lowpass_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the adaptive-gain low-pass filter top level.
// Drives samples and register writes, predicts every Q16.16 level in-line and
// checks the result stream against it. Needs only aglp_pkg and the RTL.

module adaptive_gain_lowpass_top_test;
    import aglp_pkg::*;

    localparam int SAMPLE_W       = 16;
    localparam int TDATA_W        = ((SAMPLE_W + 7) / 8) * 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int N_DIR          = 40;

    // Indexes that map to no register; writes there must change nothing.
    localparam cfg_index_t REG_SPARE_LO = 3'd5;
    localparam cfg_index_t REG_SPARE_HI = 3'd7;

    typedef logic signed [LEVEL_BITS-1:0] level_t;
    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;
    typedef struct packed {
        row_kind_e   kind;
        cfg_index_t  index;     // ignored on sample rows
        int          value;     // sample or register data
        logic        typed;     // level below is known by hand
        logic [31:0] level;
    } row_t;
    typedef enum {PAT_RAMP, PAT_HOLD, PAT_ZIGZAG, PAT_NOISE} shape_e;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata   = '0;     // [15:0] sample
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [31:0]        m_tdata;            // [31:0] filtered_value
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index = REG_SLOW_GAIN;
    cfg_data_t          cfg_data  = '0;

    // Shadow of the filter state and of the register file.
    level_t          lp_level;
    gain_t           lp_gain;
    int unsigned     lp_run;
    logic            lp_rising;
    gain_t           sh_slow;
    gain_t           sh_fast;
    logic [15:0]     sh_step_thr;
    logic [7:0]      sh_count_thr;
    logic [3:0]      sh_bonus;

    logic [31:0]     expected_levels [$];
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    logic            long_hold_req = 1'b0;
    int              stall_cycles  = 0;
    int              n_mismatch    = 0;
    int              n_samples     = 0;
    int              n_levels      = 0;
    int              n_writes      = 0;
    int              n_fast_loads  = 0;
    int              n_slow_loads  = 0;

    // Directed stimulus: reset state, gain extremes, rounding ties, spare indexes.
    row_t dir_rows [N_DIR] = '{
        // Reset gain is zero, so the level stays put until a reversal.
        '{ROW_SAMPLE, REG_SLOW_GAIN,       0,      1'b1, 32'h0000_0000},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       -32768, 1'b1, 32'h0000_0000},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       32767,  1'b0, 32'h0},
        // A sustained climb with large steps earns the bonus and the fast gain.
        '{ROW_SAMPLE, REG_SLOW_GAIN,       32767,  1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       32767,  1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       32767,  1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       32767,  1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       32767,  1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       32767,  1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       32767,  1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       32767,  1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       32767,  1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       -1,     1'b0, 32'h0},
        // Gains above one saturate, so every level equals the sample.
        '{ROW_WRITE,  REG_SLOW_GAIN,       131071, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_FAST_GAIN,       65537,  1'b0, 32'h0},
        '{ROW_WRITE,  REG_STEP_THRESHOLD,  65535,  1'b0, 32'h0},
        '{ROW_WRITE,  REG_COUNT_THRESHOLD, 0,      1'b0, 32'h0},
        '{ROW_WRITE,  REG_BIG_STEP_BONUS,  15,     1'b0, 32'h0},
        '{ROW_WRITE,  REG_SPARE_LO,        131071, 1'b0, 32'h0},
        '{ROW_WRITE,  REG_SPARE_HI,        0,      1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       32767,  1'b1, 32'h7FFF_0000},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       -32768, 1'b1, 32'h8000_0000},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       -32768, 1'b1, 32'h8000_0000},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       0,      1'b1, 32'h0000_0000},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       1,      1'b1, 32'h0001_0000},
        // Half gain leaves a level with a half-unit fraction.
        '{ROW_WRITE,  REG_SLOW_GAIN,       32768,  1'b0, 32'h0},
        '{ROW_WRITE,  REG_FAST_GAIN,       32768,  1'b0, 32'h0},
        '{ROW_WRITE,  REG_STEP_THRESHOLD,  0,      1'b0, 32'h0},
        '{ROW_WRITE,  REG_COUNT_THRESHOLD, 255,    1'b0, 32'h0},
        '{ROW_WRITE,  REG_BIG_STEP_BONUS,  0,      1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       3,      1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       0,      1'b0, 32'h0},
        // Smallest gain on a half-unit difference: the tie rounds upward.
        '{ROW_WRITE,  REG_SLOW_GAIN,       1,      1'b0, 32'h0},
        '{ROW_WRITE,  REG_FAST_GAIN,       1,      1'b0, 32'h0},
        '{ROW_WRITE,  REG_STEP_THRESHOLD,  10,     1'b0, 32'h0},
        '{ROW_WRITE,  REG_COUNT_THRESHOLD, 50,     1'b0, 32'h0},
        '{ROW_WRITE,  REG_BIG_STEP_BONUS,  5,      1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       5,      1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       -10,    1'b0, 32'h0},
        '{ROW_SAMPLE, REG_SLOW_GAIN,       -20,    1'b0, 32'h0}
    };

    adaptive_gain_lowpass_top #(
        .SAMPLE_BITS(SAMPLE_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Gains above one are held at one when loaded.
    function automatic gain_t gain_limit(input gain_t g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

    function automatic int clip_sample(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    task automatic reset_shadow();
        sh_slow      = RST_SLOW_GAIN;
        sh_fast      = RST_FAST_GAIN;
        sh_step_thr  = RST_STEP_THRESHOLD;
        sh_count_thr = RST_COUNT_THRESHOLD;
        sh_bonus     = RST_BIG_STEP_BONUS;
        lp_level     = '0;
        lp_gain      = '0;
        lp_run       = 0;
        lp_rising    = 1'b0;
    endtask

    // Advance the filter by one sample and return the new Q16.16 level.
    function automatic level_t filter_next(input logic [TDATA_W-1:0] smp);
        longint diff;
        longint mag;
        longint prod;
        longint nxt;
        logic   up;
        diff = longint'($signed(smp[SAMPLE_W-1:0])) * 65536 - longint'(lp_level);
        up = lp_rising;
        if (diff > 0)
            up = 1'b1;
        else if (diff < 0)
            up = 1'b0;

        // Same direction extends the run; a reversal restarts it on the slow gain.
        if (up == lp_rising) begin
            lp_run += 1;
            mag = (diff < 0) ? -diff : diff;
            if (mag > longint'(sh_step_thr) * 65536)
                lp_run += sh_bonus;
            if (lp_run > sh_count_thr) begin
                lp_gain = gain_limit(sh_fast);
                lp_run  = 0;
                n_fast_loads++;
            end
        end else begin
            lp_run  = 0;
            lp_gain = gain_limit(sh_slow);
            n_slow_loads++;
        end
        lp_run    = lp_run & 32'h1FF;
        lp_rising = up;

        // Round to nearest with ties upward, then saturate to 32 bits.
        prod = longint'(lp_gain) * diff + 32768;
        nxt  = longint'(lp_level) + (prod >>> 16);
        if (nxt > 64'sd2147483647)
            nxt = 64'sd2147483647;
        if (nxt < -64'sd2147483648)
            nxt = -64'sd2147483648;
        lp_level = level_t'(nxt);
        return lp_level;
    endfunction

    // Offer one sample, with random idle cycles ahead of it.
    task automatic send_sample(input logic [TDATA_W-1:0] smp, input logic typed,
                               input logic [31:0] typed_level);
        level_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        predicted = filter_next(smp);
        expected_levels.push_back(typed ? typed_level : predicted);
        n_samples++;
    endtask

    // Stop offering and wait until every expected level has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register transfer; the caller lowers cfg_valid after the last one.
    task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SLOW_GAIN:       sh_slow      = val;
            REG_FAST_GAIN:       sh_fast      = val;
            REG_STEP_THRESHOLD:  sh_step_thr  = val[THR_BITS-1:0];
            REG_COUNT_THRESHOLD: sh_count_thr = val[CTHR_BITS-1:0];
            REG_BIG_STEP_BONUS:  sh_bonus     = val[BONUS_BITS-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic load_settings(input gain_t slow, input gain_t fast,
                                 input logic [15:0] step_thr,
                                 input logic [7:0] count_thr,
                                 input logic [3:0] bonus);
        drain_results();
        write_reg(REG_SLOW_GAIN, slow);
        write_reg(REG_FAST_GAIN, fast);
        write_reg(REG_STEP_THRESHOLD, cfg_data_t'(step_thr));
        write_reg(REG_COUNT_THRESHOLD, cfg_data_t'(count_thr));
        write_reg(REG_BIG_STEP_BONUS, cfg_data_t'(bonus));
        cfg_valid <= 1'b0;
    endtask

    // Mostly usable gains and short runs, now and then a saturating gain.
    task automatic random_settings();
        gain_t       slow;
        gain_t       fast;
        logic [15:0] step_thr;
        logic [7:0]  count_thr;
        slow = ($urandom_range(0, 4) == 0) ? gain_t'($urandom_range(65537, 131071))
                                           : gain_t'($urandom_range(0, 20000));
        fast = ($urandom_range(0, 4) == 0) ? gain_t'($urandom_range(65537, 131071))
                                           : gain_t'($urandom_range(8192, 65536));
        step_thr  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
        count_thr = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30));
        load_settings(slow, fast, step_thr, count_thr, 4'($urandom_range(0, 15)));
    endtask

    // Random samples shaped as ramps, plateaus, zigzags and plain noise.
    task automatic run_segment(input int n_items, input int pause_at, input int hold_at);
        int     cur;
        int     step;
        int     span;
        int     center;
        int     len;
        int     sent;
        int     roll;
        shape_e shape;
        sent = 0;
        step = 1;
        span = 1;
        center = 0;
        cur = int'($urandom_range(0, 2000)) - 1000;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                shape = PAT_RAMP;
            else if (roll < 65)
                shape = PAT_HOLD;
            else if (roll < 85)
                shape = PAT_ZIGZAG;
            else
                shape = PAT_NOISE;
            len = $urandom_range(6, 80);
            if (shape == PAT_RAMP) begin
                step = ($urandom_range(0, 3) == 0) ? int'($urandom_range(200, 4000))
                                                   : int'($urandom_range(1, 40));
                if ($urandom_range(0, 1) == 1)
                    step = -step;
            end else if (shape == PAT_ZIGZAG) begin
                span   = $urandom_range(1, 300);
                center = cur;
            end
            for (int k = 0; k < len && sent < n_items; k++) begin
                case (shape)
                    PAT_RAMP:   cur = clip_sample(cur + step);
                    PAT_ZIGZAG: cur = clip_sample(center + ((k % 2 == 1) ? span : -span));
                    PAT_NOISE:  cur = int'($signed(16'($urandom)));
                    default: ;
                endcase
                if (sent == hold_at)
                    long_hold_req = 1'b1;
                if (sent == pause_at)
                    drain_results();
                send_sample(TDATA_W'(cur), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Result side: random back-pressure, plus one long hold on request.
    initial begin
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
                @(posedge aclk);
            end
        end
    end

    // Compare each level transfer with the oldest expectation.
    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            n_levels++;
            if (expected_levels.size() == 0) begin
                if (n_mismatch < REPORT_LIMIT)
                    $display("ERROR: level %h arrived with nothing expected at %0t",
                             m_tdata, $time);
                n_mismatch++;
            end else begin
                want = expected_levels.pop_front();
                if (m_tdata !== want) begin
                    if (n_mismatch < REPORT_LIMIT)
                        $display("ERROR: filtered_value expected %h, got %h at %0t",
                                 want, m_tdata, $time);
                    n_mismatch++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer", stall_cycles);
            $display("FAIL adaptive_gain_lowpass_top");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Main sequence.
    initial begin
        logic prev_sample;
        prev_sample = 1'b1;
        reset_shadow();
        send_idle_pct = 28;
        recv_idle_pct = 68;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table; register writes always start from an idle block.
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                if (prev_sample)
                    drain_results();
                write_reg(dir_rows[r].index, cfg_data_t'(dir_rows[r].value));
                prev_sample = 1'b0;
            end else begin
                if (!prev_sample)
                    cfg_valid <= 1'b0;
                send_sample(TDATA_W'(dir_rows[r].value), dir_rows[r].typed,
                            dir_rows[r].level);
                prev_sample = 1'b1;
            end
        end

        // Busy sender, slow receiver: low and high register extremes.
        load_settings('0, GAIN_ONE, '0, '0, '0);
        run_segment(140, -1, -1);
        load_settings(17'h1FFFF, gain_t'($urandom_range(65536, 131071)),
                      16'hFFFF, 8'hFF, 4'hF);
        run_segment(140, -1, -1);

        // Slow sender, busy receiver.
        send_idle_pct = 68;
        recv_idle_pct = 28;
        random_settings();
        run_segment(140, -1, -1);
        random_settings();
        run_segment(140, -1, -1);

        // Full rate, with one long receiver hold and one full drain mid-stream.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_settings();
        run_segment(140, 90, 30);
        random_settings();
        run_segment(150, -1, -1);

        drain_results();
        $display("Covered %0d samples and %0d levels across %0d register writes.",
                 n_samples, n_levels, n_writes);
        $display("Slow gain taken %0d times, fast gain %0d times; %0d mismatches.",
                 n_slow_loads, n_fast_loads, n_mismatch);
        if (n_mismatch == 0) begin
            $display("PASS adaptive_gain_lowpass_top");
        end else begin
            $display("FAIL adaptive_gain_lowpass_top");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/aglp_pkg.sv
hw/rtl/adaptive_gain_lowpass_top.sv
test/adaptive_gain_lowpass_top_test.sv
